### src/jfp_pkg.sv
package jfp_pkg;

  localparam int unsigned MAX_FUSE_COUNT = 65536;
  localparam int unsigned LIMIT_CAP_INT =
    (MAX_FUSE_COUNT < 65536) ? MAX_FUSE_COUNT : 65536;
  localparam logic [16:0] LIMIT_CAP = LIMIT_CAP_INT[16:0];
  localparam logic [16:0] FUSE_LIMIT_RST = 17'h10000;
  localparam logic [16:0] ADDR_SAT = 17'h1FFFF;

  localparam logic [7:0] CHAR_L    = 8'h4C;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_ONE  = 8'h31;
  localparam logic [7:0] CHAR_NINE = 8'h39;
  localparam logic [7:0] CHAR_NUL  = 8'h00;

  // Register indexes of the configuration port.
  localparam logic REG_FUSE_LIMIT = 1'b0;

  typedef struct packed {
    logic [15:0] fuse_address;
    logic        fuse_value;
    logic        is_summary;
    logic [16:0] fuse_count;
    logic        run_end;
  } jfp_res_t;

  typedef struct packed {
    logic [1:0] count;
    jfp_res_t   first;
    jfp_res_t   second;
  } jfp_push_t;

  function automatic logic is_letter(input logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
  endfunction

  function automatic logic is_white(input logic [7:0] b);
    return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
  endfunction

  function automatic logic is_gap(input logic [7:0] b);
    return (b >= 8'h01 && b <= 8'h20) || (b == 8'h7F);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CHAR_ZERO) && (b <= CHAR_NINE);
  endfunction

endpackage

### src/jfp_in_if.sv
interface jfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       final_byte;

  modport source (output valid, output text_byte, output final_byte, input ready);
  modport sink (input valid, input text_byte, input final_byte, output ready);
endinterface

### src/jfp_out_if.sv
interface jfp_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] fuse_address;
  logic        fuse_value;
  logic        is_summary;
  logic [16:0] fuse_count;
  logic        run_end;

  modport source (output valid, output fuse_address, output fuse_value,
                  output is_summary, output fuse_count, output run_end, input ready);
  modport sink (input valid, input fuse_address, input fuse_value,
                input is_summary, input fuse_count, input run_end, output ready);
endinterface

### src/jfp_scan.sv
module jfp_scan (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic [7:0]         text_byte,
  input  logic               final_byte,
  input  logic [16:0]        fuse_limit,
  output jfp_pkg::jfp_push_t push
);
  import jfp_pkg::*;

  localparam logic [2:0] PH_SEARCH    = 3'd0;
  localparam logic [2:0] PH_AFTER_L   = 3'd1;
  localparam logic [2:0] PH_ADDR      = 3'd2;
  localparam logic [2:0] PH_GAP_FIRST = 3'd3;
  localparam logic [2:0] PH_GAP_NEXT  = 3'd4;

  logic [2:0]  phase_r, phase_nxt;
  logic        prev_letter_r, prev_letter_nxt;
  logic [16:0] addr_r, addr_nxt;
  logic [16:0] high_r, high_nxt;
  logic        ended_r, ended_nxt;

  logic [16:0] eff_limit;
  logic [20:0] addr_mul;
  logic [16:0] addr_inc;
  logic        rescan;
  logic        wr;
  jfp_res_t    wr_res;
  jfp_res_t    sum_res;

  assign eff_limit = (fuse_limit > LIMIT_CAP) ? LIMIT_CAP : fuse_limit;
  // Address times ten plus the new digit, as two shifted adds.
  assign addr_mul = {1'b0, addr_r, 3'b000} + {3'b000, addr_r, 1'b0}
                  + {17'd0, text_byte[3:0]};
  assign addr_inc = addr_r + 17'd1;

  always_comb begin
    phase_nxt       = phase_r;
    prev_letter_nxt = prev_letter_r;
    addr_nxt        = addr_r;
    high_nxt        = high_r;
    ended_nxt       = ended_r;
    rescan          = 1'b0;
    wr              = 1'b0;
    if (!ended_r) begin
      if (text_byte == CHAR_NUL) begin
        ended_nxt = 1'b1;
        phase_nxt = PH_SEARCH;
      end else begin
        case (phase_r)
          PH_AFTER_L: begin
            if (is_digit(text_byte)) begin
              addr_nxt  = {13'd0, text_byte[3:0]};
              phase_nxt = PH_ADDR;
            end else if (!is_white(text_byte)) begin
              rescan = 1'b1;
            end
          end
          PH_ADDR: begin
            if (is_digit(text_byte)) begin
              addr_nxt = (addr_mul > {4'd0, ADDR_SAT}) ? ADDR_SAT : addr_mul[16:0];
            end else if (is_white(text_byte)) begin
              phase_nxt = PH_GAP_FIRST;
            end else begin
              rescan = 1'b1;
            end
          end
          PH_GAP_FIRST, PH_GAP_NEXT: begin
            if (text_byte == CHAR_ZERO || text_byte == CHAR_ONE) begin
              if (addr_r < eff_limit) begin
                wr        = 1'b1;
                addr_nxt  = addr_inc;
                high_nxt  = (addr_inc > high_r) ? addr_inc : high_r;
                phase_nxt = PH_GAP_NEXT;
              end else begin
                rescan = 1'b1;
              end
            end else if (phase_r == PH_GAP_FIRST ? !is_white(text_byte)
                                                 : !is_gap(text_byte)) begin
              rescan = 1'b1;
            end
          end
          default: begin
            rescan = 1'b1;
          end
        endcase
        // A byte that ends a field is looked at again as ordinary text.
        if (rescan) begin
          phase_nxt = (text_byte == CHAR_L && !prev_letter_r) ? PH_AFTER_L : PH_SEARCH;
        end
        prev_letter_nxt = is_letter(text_byte);
      end
    end
  end

  always_comb begin
    wr_res              = '0;
    wr_res.fuse_address = addr_r[15:0];
    wr_res.fuse_value   = text_byte[0];
    wr_res.run_end      = !final_byte;
    sum_res             = '0;
    sum_res.is_summary  = 1'b1;
    sum_res.fuse_count  = high_nxt;
    sum_res.run_end     = 1'b1;

    push        = '0;
    push.first  = wr ? wr_res : sum_res;
    push.second = sum_res;
    if (accept) begin
      push.count = {1'b0, wr} + {1'b0, final_byte};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_SEARCH;
      prev_letter_r <= 1'b0;
      addr_r        <= '0;
      high_r        <= '0;
      ended_r       <= 1'b0;
    end else if (accept) begin
      if (final_byte) begin
        // The next byte starts a new file.
        phase_r       <= PH_SEARCH;
        prev_letter_r <= 1'b0;
        addr_r        <= '0;
        high_r        <= '0;
        ended_r       <= 1'b0;
      end else begin
        phase_r       <= phase_nxt;
        prev_letter_r <= prev_letter_nxt;
        addr_r        <= addr_nxt;
        high_r        <= high_nxt;
        ended_r       <= ended_nxt;
      end
    end
  end

endmodule

### src/jfp_res_q.sv
module jfp_res_q (
  input  logic               clk,
  input  logic               rst_n,
  input  jfp_pkg::jfp_push_t push,
  input  logic               pop,
  output logic               has_room,
  output logic               not_empty,
  output jfp_pkg::jfp_res_t  head
);
  import jfp_pkg::*;

  jfp_res_t   mem_r [4];
  logic [1:0] wr_ptr_r, wr_ptr_nxt;
  logic [1:0] rd_ptr_r, rd_ptr_nxt;
  logic [2:0] count_r, count_nxt;
  logic       do_pop;

  // Room is kept for the two results that one item can cause.
  assign has_room   = (count_r <= 3'd2);
  assign not_empty  = (count_r != 3'd0);
  assign head       = mem_r[rd_ptr_r];
  assign do_pop     = pop && not_empty;
  assign wr_ptr_nxt = wr_ptr_r + push.count;
  assign rd_ptr_nxt = rd_ptr_r + {1'b0, do_pop};
  assign count_nxt  = count_r + {1'b0, push.count} - {2'b00, do_pop};

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem_r[wr_ptr_r] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem_r[wr_ptr_r + 2'd1] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

### src/jedec_fuse_field_parser.sv
// Fuse field parser: takes the text of a fuse file one byte per item and
// gives one result item per fuse written by an L field, plus an end-of-file
// summary after the byte marked final_byte. A byte is accepted in every cycle
// while the four-entry result queue has room for two more results; results
// leave at one per cycle while the sink is ready, so the rate is one byte per
// cycle; a final byte that also writes a fuse gives two results. The scanner
// decides each byte in the cycle it is accepted. fuse_limit is written
// through the APB port at byte address 0 and may be changed only while idle.
module jedec_fuse_field_parser (
  input  logic        clk,
  input  logic        rst_n,
  jfp_in_if.sink      in_chan,
  jfp_out_if.source   out_chan,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import jfp_pkg::*;

  logic [16:0] fuse_limit_r;
  logic        cfg_wr;
  logic        in_accept;
  logic        has_room;
  jfp_push_t   push;
  jfp_res_t    head;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[2] == REG_FUSE_LIMIT) ? {15'd0, fuse_limit_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fuse_limit_r <= FUSE_LIMIT_RST;
    end else if (cfg_wr && cfg_paddr[2] == REG_FUSE_LIMIT) begin
      fuse_limit_r <= cfg_pwdata[16:0];
    end
  end

  assign in_chan.ready = has_room;
  assign in_accept     = in_chan.valid && has_room;

  jfp_scan u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (in_accept),
    .text_byte  (in_chan.text_byte),
    .final_byte (in_chan.final_byte),
    .fuse_limit (fuse_limit_r),
    .push       (push)
  );

  jfp_res_q u_res_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .pop       (out_chan.ready),
    .has_room  (has_room),
    .not_empty (out_chan.valid),
    .head      (head)
  );

  assign out_chan.fuse_address = head.fuse_address;
  assign out_chan.fuse_value   = head.fuse_value;
  assign out_chan.is_summary   = head.is_summary;
  assign out_chan.fuse_count   = head.fuse_count;
  assign out_chan.run_end      = head.run_end;

endmodule

### tb/sv/tb_jedec_fuse_field_parser.sv
module tb_jedec_fuse_field_parser;
  import jfp_pkg::*;

  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_STAR  = 8'h2A;
  localparam logic [7:0] CHAR_DEL   = 8'h7F;

  typedef enum logic [2:0] {FIND_L, AT_L, IN_ADDR, FIRST_GAP, NEXT_GAP} scan_e;

  typedef struct packed {
    logic [7:0] text;
    logic       last;
  } text_item_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  jfp_in_if  text_in ();
  jfp_out_if fuse_out ();

  jedec_fuse_field_parser u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (text_in),
    .out_chan    (fuse_out),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  text_item_t  pending_bytes[$];
  logic [7:0]  file_text[$];
  jfp_res_t    expected_fuses[$];
  text_item_t  offer_item;
  jfp_res_t    want_res;
  int          send_idle_pct;
  int          recv_idle_pct;
  logic        rx_freeze;
  int          error_count;

  // Shadow of the parser: scan state, fuse bookkeeping and the limit register.
  scan_e       scan_state;
  logic        prev_letter;
  logic [16:0] cur_addr;
  logic [16:0] high_end;
  logic        text_done;
  logic [16:0] fuse_limit_now;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic logic letter_char(input logic [7:0] b);
    return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
  endfunction

  function automatic logic blank_char(input logic [7:0] b);
    return (b == CHAR_SPACE) || (b >= 8'h09 && b <= 8'h0D);
  endfunction

  function automatic logic filler_char(input logic [7:0] b);
    return (b >= 8'h01 && b <= CHAR_SPACE) || (b == CHAR_DEL);
  endfunction

  function automatic logic decimal_char(input logic [7:0] b);
    return (b >= CHAR_ZERO) && (b <= CHAR_NINE);
  endfunction

  function automatic logic [16:0] usable_limit();
    return (fuse_limit_now > LIMIT_CAP) ? LIMIT_CAP : fuse_limit_now;
  endfunction

  function automatic void clear_scan();
    scan_state  = FIND_L;
    prev_letter = 1'b0;
    cur_addr    = '0;
    high_end    = '0;
    text_done   = 1'b0;
  endfunction

  // A byte that ends a field is looked at a second time as plain text.
  function automatic void scan_char(input logic [7:0] b, output logic wrote,
                                    output logic [15:0] w_addr, output logic w_val);
    logic        again;
    logic [31:0] acc;
    wrote  = 1'b0;
    w_addr = '0;
    w_val  = 1'b0;
    again  = 1'b1;
    for (int pass = 0; pass < 2 && again; pass++) begin
      again = 1'b0;
      case (scan_state)
        AT_L: begin
          if (decimal_char(b)) begin
            cur_addr   = 17'(b - CHAR_ZERO);
            scan_state = IN_ADDR;
          end else if (!blank_char(b)) begin
            scan_state = FIND_L;
            again      = 1'b1;
          end
        end
        IN_ADDR: begin
          if (decimal_char(b)) begin
            acc      = 32'(cur_addr) * 32'd10 + 32'(b - CHAR_ZERO);
            cur_addr = (acc > 32'(ADDR_SAT)) ? ADDR_SAT : acc[16:0];
          end else if (blank_char(b)) begin
            scan_state = FIRST_GAP;
          end else begin
            scan_state = FIND_L;
            again      = 1'b1;
          end
        end
        FIRST_GAP, NEXT_GAP: begin
          if (b == CHAR_ZERO || b == CHAR_ONE) begin
            if (cur_addr < usable_limit()) begin
              wrote    = 1'b1;
              w_addr   = cur_addr[15:0];
              w_val    = (b == CHAR_ONE);
              cur_addr = cur_addr + 17'd1;
              if (cur_addr > high_end) begin
                high_end = cur_addr;
              end
              scan_state = NEXT_GAP;
            end else begin
              scan_state = FIND_L;
              again      = 1'b1;
            end
          end else if (!((scan_state == FIRST_GAP) ? blank_char(b) : filler_char(b))) begin
            scan_state = FIND_L;
            again      = 1'b1;
          end
        end
        default: begin
          scan_state = (b == CHAR_L && !prev_letter) ? AT_L : FIND_L;
        end
      endcase
    end
  endfunction

  function automatic void predict_fuses(input logic [7:0] b, input logic fin);
    logic        wrote;
    logic [15:0] w_addr;
    logic        w_val;
    jfp_res_t    r;
    wrote = 1'b0;
    if (!text_done) begin
      if (b == CHAR_NUL) begin
        text_done  = 1'b1;
        scan_state = FIND_L;
      end else begin
        scan_char(b, wrote, w_addr, w_val);
        prev_letter = letter_char(b);
      end
    end
    if (wrote) begin
      r.fuse_address = w_addr;
      r.fuse_value   = w_val;
      r.is_summary   = 1'b0;
      r.fuse_count   = '0;
      r.run_end      = !fin;
      expected_fuses.push_back(r);
    end
    if (fin) begin
      r.fuse_address = '0;
      r.fuse_value   = 1'b0;
      r.is_summary   = 1'b1;
      r.fuse_count   = high_end;
      r.run_end      = 1'b1;
      expected_fuses.push_back(r);
      clear_scan();
    end
  endfunction

  // Byte driver.
  always @(posedge clk) begin
    if (!rst_n) begin
      text_in.valid <= 1'b0;
    end else begin
      if (text_in.valid && text_in.ready) begin
        predict_fuses(text_in.text_byte, text_in.final_byte);
      end
      if (!text_in.valid || text_in.ready) begin
        if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          offer_item = pending_bytes.pop_front();
          text_in.valid      <= 1'b1;
          text_in.text_byte  <= offer_item.text;
          text_in.final_byte <= offer_item.last;
        end else begin
          text_in.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and checker.
  always @(posedge clk) begin
    if (!rst_n) begin
      fuse_out.ready <= 1'b0;
    end else begin
      if (fuse_out.valid && fuse_out.ready) begin
        if (expected_fuses.size() == 0) begin
          $display("%0t: unexpected result addr=%0d val=%0d summary=%0d count=%0d end=%0d",
                   $time, fuse_out.fuse_address, fuse_out.fuse_value,
                   fuse_out.is_summary, fuse_out.fuse_count, fuse_out.run_end);
          error_count++;
        end else begin
          want_res = expected_fuses.pop_front();
          if (want_res.fuse_address != fuse_out.fuse_address ||
              want_res.fuse_value != fuse_out.fuse_value ||
              want_res.is_summary != fuse_out.is_summary ||
              want_res.fuse_count != fuse_out.fuse_count ||
              want_res.run_end != fuse_out.run_end) begin
            $display("%0t: mismatch expected addr=%0d val=%0d summary=%0d count=%0d end=%0d",
                     $time, want_res.fuse_address, want_res.fuse_value,
                     want_res.is_summary, want_res.fuse_count, want_res.run_end);
            $display("%0t:          actual   addr=%0d val=%0d summary=%0d count=%0d end=%0d",
                     $time, fuse_out.fuse_address, fuse_out.fuse_value,
                     fuse_out.is_summary, fuse_out.fuse_count, fuse_out.run_end);
            error_count++;
          end
        end
      end
      fuse_out.ready <= !rx_freeze && ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  task automatic write_fuse_limit(input logic [16:0] value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {REG_FUSE_LIMIT, 2'b00};
    cfg_pwdata  <= 32'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel       <= 1'b0;
    cfg_penable    <= 1'b0;
    cfg_pwrite     <= 1'b0;
    fuse_limit_now = value;
  endtask

  // Waits until every byte has gone in and every fuse result has come out.
  task automatic wait_drained();
    int guard;
    guard = 0;
    while ((pending_bytes.size() != 0 || text_in.valid || expected_fuses.size() != 0) &&
           guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      file_text.push_back(s[i]);
    end
  endtask

  task automatic add_decimal(input int unsigned v, input logic lead_zero);
    if (lead_zero) begin
      file_text.push_back(CHAR_ZERO);
    end
    add_text($sformatf("%0d", v));
  endtask

  function automatic logic [7:0] rand_blank();
    return ($urandom_range(0, 2) == 0) ? CHAR_SPACE : 8'($urandom_range(8'h09, 8'h0D));
  endfunction

  function automatic logic [7:0] rand_filler();
    return ($urandom_range(0, 9) == 0) ? CHAR_DEL : 8'($urandom_range(8'h01, 8'h20));
  endfunction

  // Moves the text of one file to the driver, marking its last byte.
  task automatic flush_file();
    text_item_t it;
    for (int i = 0; i < file_text.size(); i++) begin
      it.text = file_text[i];
      it.last = (i == file_text.size() - 1);
      pending_bytes.push_back(it);
    end
    file_text.delete();
  endtask

  task automatic add_l_field();
    int unsigned kind;
    int unsigned addr;
    int unsigned lim;
    int unsigned ndig;
    int unsigned pick;
    kind = $urandom_range(0, 11);
    lim  = 32'(usable_limit());
    if (file_text.size() != 0 || $urandom_range(0, 1) == 1) begin
      pick = $urandom_range(0, 2);
      file_text.push_back(pick == 0 ? CHAR_LF : (pick == 1 ? CHAR_STAR : CHAR_SPACE));
    end
    if (kind == 0) begin
      // A letter right before L hides the field.
      file_text.push_back(8'($urandom_range("A", "Z")));
      add_text("L12 1");
    end else if (kind == 1) begin
      file_text.push_back(CHAR_L);
      file_text.push_back($urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS);
      add_decimal($urandom_range(0, 20), 1'b0);
      add_text(" 10");
    end else if (kind == 2) begin
      file_text.push_back(CHAR_L);
      if ($urandom_range(0, 1) == 1) begin
        file_text.push_back(rand_blank());
      end
      file_text.push_back($urandom_range(0, 1) ? CHAR_STAR : CHAR_L);
    end else begin
      file_text.push_back(CHAR_L);
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 2)) file_text.push_back(rand_blank());
      end
      pick = $urandom_range(0, 7);
      if (pick <= 3) begin
        addr = $urandom_range(0, 40);
      end else if (pick <= 5) begin
        addr = ((lim > 3) ? lim - 3 : 0) + $urandom_range(0, 4);
      end else if (pick == 6) begin
        addr = $urandom_range(65530, 65540);
      end else begin
        addr = $urandom_range(131000, 9999999);
      end
      add_decimal(addr, $urandom_range(0, 7) == 0);
      if ($urandom_range(0, 11) == 0) begin
        file_text.push_back($urandom_range(0, 1) ? CHAR_STAR : 8'h78);
      end
      repeat ($urandom_range(1, 2)) file_text.push_back(rand_blank());
      ndig = $urandom_range(0, 14);
      for (int j = 0; j < ndig; j++) begin
        if (j > 0) begin
          repeat ($urandom_range(0, 2)) file_text.push_back(rand_filler());
        end
        if ($urandom_range(0, 19) == 0) begin
          file_text.push_back(8'($urandom_range("2", "9")));
        end else begin
          file_text.push_back($urandom_range(0, 1) ? CHAR_ONE : CHAR_ZERO);
        end
      end
      pick = $urandom_range(0, 8);
      if (pick <= 6) begin
        file_text.push_back(CHAR_STAR);
      end else if (pick == 7) begin
        file_text.push_back(8'($urandom_range(8'h21, 8'h7E)));
      end
    end
  endtask

  task automatic add_fuse_file();
    if ($urandom_range(0, 19) == 0) begin
      file_text.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 4)) begin
        add_l_field();
        if ($urandom_range(0, 5) == 0) begin
          repeat ($urandom_range(1, 4)) file_text.push_back(8'($urandom_range(1, 255)));
        end
      end
      if ($urandom_range(0, 15) == 0) begin
        // Bytes after the zero byte are ignored up to the end of the file.
        file_text.push_back(CHAR_NUL);
        add_text("L1 1");
      end
    end
    flush_file();
  endtask

  task automatic run_phase(input int unsigned n_bytes);
    @(negedge clk);
    while (pending_bytes.size() < n_bytes) begin
      add_fuse_file();
    end
  endtask

  initial begin
    rst_n              = 1'b0;
    rx_freeze          = 1'b0;
    error_count        = 0;
    send_idle_pct      = 14;
    recv_idle_pct      = 62;
    text_in.valid      = 1'b0;
    text_in.text_byte  = '0;
    text_in.final_byte = 1'b0;
    fuse_out.ready     = 1'b0;
    cfg_psel           = 1'b0;
    cfg_penable        = 1'b0;
    cfg_pwrite         = 1'b0;
    cfg_paddr          = '0;
    cfg_pwdata         = '0;
    fuse_limit_now     = FUSE_LIMIT_RST;
    clear_scan();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Top address then a digit past the limit, a signed address, a saturating
    // address, the zero byte and a high byte closing the file.
    @(negedge clk);
    add_text("L65535 10L-2 1L999999 1");
    file_text.push_back(CHAR_NUL);
    file_text.push_back(8'hFF);
    flush_file();
    wait_drained();

    write_fuse_limit(17'd1);
    run_phase(300);
    wait_drained();

    write_fuse_limit(17'($urandom_range(2, 64)));
    run_phase(400);
    wait_drained();

    send_idle_pct <= 62;
    recv_idle_pct <= 14;
    write_fuse_limit(17'($urandom_range(65, 65535)));
    run_phase(450);
    wait_drained();

    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    write_fuse_limit(17'd65536);
    run_phase(600);
    // The sender keeps offering bytes while results back up.
    rx_freeze <= 1'b1;
    repeat (200) @(posedge clk);
    rx_freeze <= 1'b0;
    wait_drained();

    if (expected_fuses.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_fuses.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("%0t: timeout", $time);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
